// File: rtl/uitx_pkg.sv
// Shared types, codes and constants of the UART interrupt transfer engine.
package uitx_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NINE_BIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTS_IRQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_IRQ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_IRQ = 3'd5;

    localparam logic [1:0] CMD_START_TX = 2'd0;
    localparam logic [1:0] CMD_START_RX = 2'd1;
    localparam logic [1:0] CMD_SERVICE  = 2'd2;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_TX_WRITE = 2'd1;
    localparam logic [1:0] KIND_RX_STORE = 2'd2;
    localparam logic [1:0] KIND_EVENT    = 2'd3;

    localparam logic [2:0] EV_TX_DONE = 3'd0;
    localparam logic [2:0] EV_RX_DONE = 3'd1;
    localparam logic [2:0] EV_CTS     = 3'd2;
    localparam logic [2:0] EV_IDLE    = 3'd3;
    localparam logic [2:0] EV_OVERRUN = 3'd4;
    localparam logic [2:0] EV_FRAMING = 3'd5;
    localparam logic [2:0] EV_NOISE   = 3'd6;

    localparam logic [8:0] MASK9 = 9'h1FF;
    localparam logic [8:0] MASK8 = 9'h0FF;
    localparam logic [8:0] MASK7 = 9'h07F;

    // result slots, in emission order
    localparam int NSLOT  = 11;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam logic [SLOT_W-1:0] SLOT_START    = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_TX_DONE  = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_TX_WRITE = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_RX_STORE = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_RX_DONE  = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_CTS      = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_IDLE     = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_ORE_RX   = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_FRAMING  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_NOISE    = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_ORE_ERR  = 4'd10;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] length;
        logic [15:0] tx_word;
        logic [8:0]  rx_data;
        logic        flag_tc;
        logic        flag_txe;
        logic        flag_rxne;
        logic        flag_cts;
        logic        flag_idle;
        logic        flag_overrun;
        logic        flag_framing;
        logic        flag_noise;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  value;
        logic [15:0] buffer_offset;
        logic [1:0]  byte_count;
        logic [2:0]  event_code;
        logic        was_busy;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic                 value;
    } t_cfg_item;

    typedef struct packed {
        logic [NSLOT-1:0] pend;
        logic [8:0]       tx_value;
        logic [15:0]      tx_offset;
        logic [8:0]       rx_value;
        logic [15:0]      rx_offset;
        logic [1:0]       step;
        logic             was_busy;
    } t_res_set;

endpackage

// File: rtl/uitx_stream_if.sv
// Valid/ready channel carrying one item payload.
interface uitx_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/uitx_drain.sv
// Result drain: holds the results of one item and sends them one per cycle while the output is ready.
module uitx_drain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  uitx_pkg::t_res_set i_set,
    output logic              o_free,
    uitx_stream_if.source     o_out
);
    import uitx_pkg::*;

    logic [NSLOT-1:0] r_pend;
    logic [NSLOT-1:0] n_pend;
    t_res_set         r_set;
    logic [NSLOT-1:0] w_first;
    logic [SLOT_W-1:0] w_idx;
    logic             w_last;
    logic             w_take;
    t_out_item        w_item;

    assign w_first = r_pend & (~r_pend + NSLOT'(1));
    assign w_last  = (r_pend & (r_pend - NSLOT'(1))) == '0;
    assign w_take  = o_out.valid && o_out.ready;
    assign o_free  = (r_pend == '0) || (w_take && w_last);

    always_comb begin
        w_idx = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                w_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        w_item      = '0;
        w_item.kind = KIND_EVENT;
        w_item.last = w_last;
        case (w_idx)
            SLOT_START: begin
                w_item.kind     = KIND_START;
                w_item.was_busy = r_set.was_busy;
            end
            SLOT_TX_WRITE: begin
                w_item.kind          = KIND_TX_WRITE;
                w_item.value         = r_set.tx_value;
                w_item.buffer_offset = r_set.tx_offset;
                w_item.byte_count    = r_set.step;
            end
            SLOT_RX_STORE: begin
                w_item.kind          = KIND_RX_STORE;
                w_item.value         = r_set.rx_value;
                w_item.buffer_offset = r_set.rx_offset;
                w_item.byte_count    = r_set.step;
            end
            SLOT_TX_DONE:  w_item.event_code = EV_TX_DONE;
            SLOT_RX_DONE:  w_item.event_code = EV_RX_DONE;
            SLOT_CTS:      w_item.event_code = EV_CTS;
            SLOT_IDLE:     w_item.event_code = EV_IDLE;
            SLOT_ORE_RX:   w_item.event_code = EV_OVERRUN;
            SLOT_FRAMING:  w_item.event_code = EV_FRAMING;
            SLOT_NOISE:    w_item.event_code = EV_NOISE;
            SLOT_ORE_ERR:  w_item.event_code = EV_OVERRUN;
            default:       w_item.event_code = EV_TX_DONE;
        endcase
    end

    assign o_out.valid = r_pend != '0;
    assign o_out.data  = w_item;

    always_comb begin
        n_pend = r_pend;
        if (w_take) begin
            n_pend = r_pend & ~w_first;
        end
        if (i_load) begin
            n_pend = i_set.pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

endmodule

// File: rtl/uart_interrupt_transfer_engine_top.sv
// Top level of the UART interrupt transfer engine: command decode, transfer state, result drain.
// An item is taken into an input register, handled against the transfer state once the
// drain is free, and its results (none to eight) leave from the drain one per cycle while
// the output is ready, in order, with last set on the final one. The input register is
// freed as soon as the drain can take the next item's results, so items with at most one
// result flow at one per cycle while the output is ready. Start commands give one reply;
// service items give transmit, receive and event results.
module uart_interrupt_transfer_engine_top #(
    parameter int LENGTH_BITS = uitx_pkg::LENGTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uitx_stream_if.sink   i_cfg,
    uitx_stream_if.sink   i_in,
    uitx_stream_if.source o_out
);
    import uitx_pkg::*;

    // configuration
    logic r_nine_bit, r_parity, r_cts_on, r_cts_irq, r_idle_irq, r_error_irq;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // transfer state
    logic                   r_tx_busy, n_tx_busy;
    logic                   r_rx_busy, n_rx_busy;
    logic [LENGTH_BITS-1:0] r_tx_rem, n_tx_rem;
    logic [LENGTH_BITS-1:0] r_rx_rem, n_rx_rem;
    logic [LENGTH_BITS-1:0] r_tx_off, n_tx_off;
    logic [LENGTH_BITS-1:0] r_rx_off, n_rx_off;
    logic                   r_txe_en, n_txe_en;
    logic                   r_tc_en, n_tc_en;
    logic                   r_rxne_en, n_rxne_en;

    logic                   w_free;
    logic                   w_proc;
    logic                   w_take_in;
    logic [1:0]             w_step;
    logic [LENGTH_BITS-1:0] w_step_l;
    logic                   w_txe_act, w_rxne_act;
    t_res_set               w_set;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nine_bit  <= 1'b0;
            r_parity    <= 1'b0;
            r_cts_on    <= 1'b0;
            r_cts_irq   <= 1'b0;
            r_idle_irq  <= 1'b0;
            r_error_irq <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_NINE_BIT:  r_nine_bit  <= i_cfg.data.value;
                CFG_PARITY:    r_parity    <= i_cfg.data.value;
                CFG_CTS:       r_cts_on    <= i_cfg.data.value;
                CFG_CTS_IRQ:   r_cts_irq   <= i_cfg.data.value;
                CFG_IDLE_IRQ:  r_idle_irq  <= i_cfg.data.value;
                CFG_ERROR_IRQ: r_error_irq <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    assign w_proc      = r_in_valid && w_free;
    assign i_in.ready  = !r_in_valid || w_free;
    assign w_take_in   = i_in.valid && i_in.ready;
    assign w_step      = (r_nine_bit && !r_parity) ? 2'd2 : 2'd1;
    assign w_step_l    = LENGTH_BITS'(w_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in <= i_in.data;
        end
    end

    always_comb begin
        n_tx_busy  = r_tx_busy;
        n_rx_busy  = r_rx_busy;
        n_tx_rem   = r_tx_rem;
        n_rx_rem   = r_rx_rem;
        n_tx_off   = r_tx_off;
        n_rx_off   = r_rx_off;
        n_txe_en   = r_txe_en;
        n_tc_en    = r_tc_en;
        n_rxne_en  = r_rxne_en;
        w_txe_act  = 1'b0;
        w_rxne_act = 1'b0;

        w_set           = '0;
        w_set.step      = w_step;
        w_set.tx_offset = 16'(r_tx_off);
        w_set.rx_offset = 16'(r_rx_off);
        w_set.tx_value  = 9'(r_in.tx_word) & (r_nine_bit ? MASK9 : MASK8);
        w_set.rx_value  = r_in.rx_data &
                          (r_nine_bit ? (r_parity ? MASK8 : MASK9)
                                      : (r_parity ? MASK7 : MASK8));

        case (r_in.command)
            CMD_START_TX: begin
                w_set.pend[SLOT_START] = 1'b1;
                w_set.was_busy         = r_tx_busy;
                if (!r_tx_busy) begin
                    n_tx_rem  = LENGTH_BITS'(r_in.length);
                    n_tx_off  = '0;
                    n_tx_busy = 1'b1;
                    n_txe_en  = 1'b1;
                    n_tc_en   = 1'b1;
                end
            end
            CMD_START_RX: begin
                w_set.pend[SLOT_START] = 1'b1;
                w_set.was_busy         = r_rx_busy;
                if (!r_rx_busy) begin
                    n_rx_rem  = LENGTH_BITS'(r_in.length);
                    n_rx_off  = '0;
                    n_rx_busy = 1'b1;
                    n_rxne_en = 1'b1;
                end
            end
            CMD_SERVICE: begin
                if (r_in.flag_tc && r_tc_en && r_tx_busy && r_tx_rem == '0) begin
                    n_tc_en                  = 1'b0;
                    n_tx_busy                = 1'b0;
                    w_set.pend[SLOT_TX_DONE] = 1'b1;
                end
                w_txe_act = r_in.flag_txe && r_txe_en && n_tx_busy;
                if (w_txe_act) begin
                    if (r_tx_rem != '0) begin
                        w_set.pend[SLOT_TX_WRITE] = 1'b1;
                        n_tx_off = r_tx_off + w_step_l;
                        n_tx_rem = (r_tx_rem > w_step_l) ? r_tx_rem - w_step_l : '0;
                    end
                    if (n_tx_rem == '0) begin
                        n_txe_en = 1'b0;
                    end
                end
                w_rxne_act = r_in.flag_rxne && r_rxne_en && r_rx_busy;
                if (w_rxne_act) begin
                    if (r_rx_rem != '0) begin
                        w_set.pend[SLOT_RX_STORE] = 1'b1;
                        n_rx_off = r_rx_off + w_step_l;
                        n_rx_rem = (r_rx_rem > w_step_l) ? r_rx_rem - w_step_l : '0;
                    end
                    if (n_rx_rem == '0) begin
                        n_rxne_en                = 1'b0;
                        n_rx_busy                = 1'b0;
                        w_set.pend[SLOT_RX_DONE] = 1'b1;
                    end
                end
                w_set.pend[SLOT_CTS]     = r_in.flag_cts && r_cts_on && r_cts_irq;
                w_set.pend[SLOT_IDLE]    = r_in.flag_idle && r_idle_irq;
                w_set.pend[SLOT_ORE_RX]  = r_in.flag_overrun && n_rxne_en;
                w_set.pend[SLOT_FRAMING] = r_in.flag_framing && r_error_irq;
                w_set.pend[SLOT_NOISE]   = r_in.flag_noise && r_error_irq;
                w_set.pend[SLOT_ORE_ERR] = r_in.flag_overrun && r_error_irq;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_busy <= 1'b0;
            r_rx_busy <= 1'b0;
            r_tx_rem  <= '0;
            r_rx_rem  <= '0;
            r_tx_off  <= '0;
            r_rx_off  <= '0;
            r_txe_en  <= 1'b0;
            r_tc_en   <= 1'b0;
            r_rxne_en <= 1'b0;
        end else if (w_proc) begin
            r_tx_busy <= n_tx_busy;
            r_rx_busy <= n_rx_busy;
            r_tx_rem  <= n_tx_rem;
            r_rx_rem  <= n_rx_rem;
            r_tx_off  <= n_tx_off;
            r_rx_off  <= n_rx_off;
            r_txe_en  <= n_txe_en;
            r_tc_en   <= n_tc_en;
            r_rxne_en <= n_rxne_en;
        end
    end

    uitx_drain u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_proc && (w_set.pend != '0)),
        .i_set   (w_set),
        .o_free  (w_free),
        .o_out   (o_out)
    );

    a_rx_enable_tracks_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_rxne_en == r_rx_busy
    ) else $error("receive enable and receive busy disagree");

    a_start_tx_sets_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.command == CMD_START_TX && !r_tx_busy) |=> r_tx_busy && r_txe_en
    ) else $error("idle start transmit did not set busy");

    a_held_item_stable: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_free) |=> r_in_valid && $stable(r_in)
    ) else $error("stalled input item lost or changed");

    a_state_frozen_without_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !w_proc |=> $stable(r_tx_rem) && $stable(r_rx_rem) && $stable(r_tx_busy)
    ) else $error("transfer state changed with no item handled");

endmodule
